FILE: sv/bitc_pkg.sv
// Shared types and constants for the binary input telegram controller.
package bitc_pkg;

  localparam int unsigned MaxPorts      = 8;
  localparam int unsigned NumPortsDef   = 8;
  localparam int unsigned TimerBitsDef  = 12;
  localparam int unsigned CfgIdxBits    = 3;
  localparam int unsigned CfgDataBits   = 64;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegAppRunning = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegPortFunc   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegPortModes  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegPwrModes   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegPwrDelay   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegTimerBases = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegT1Factors  = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegT2Factors  = 3'd7;

  // function codes
  localparam logic [3:0] FnSwitch = 4'd1;
  localparam logic [3:0] FnBlind  = 4'd3;

  // edge / power-on rule codes
  localparam logic [1:0] RuleNone   = 2'd0;
  localparam logic [1:0] RuleOn     = 2'd1;
  localparam logic [1:0] RuleOff    = 2'd2;
  localparam logic [1:0] RuleToggle = 2'd3;

  typedef enum logic [1:0] {
    PhWait  = 2'd0,
    PhFirst = 2'd1,
    PhSecond = 2'd2,
    PhHold  = 2'd3
  } blind_phase_e;

  // per-lane request: up to two telegrams (object one, object two)
  typedef struct packed {
    logic one_vld;
    logic one_val;
    logic two_vld;
    logic two_val;
  } lane_req_t;

  // per-lane context for one tick
  typedef struct packed {
    logic       run;      // normal tick processing
    logic       pwr;      // power-on telegrams
    logic       changed;
    logic       level;
    logic       stored;
  } lane_ctl_t;

endpackage

FILE: sv/bitc_lane.sv
// One port lane: switch and blind handlers with their per-port state.
module bitc_lane #(
  parameter int unsigned TimerBits = bitc_pkg::TimerBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bitc_pkg::lane_ctl_t ctl_i,
  input  logic [3:0]          func_i,
  input  logic [7:0]          mode_i,
  input  logic [1:0]          pwr_mode_i,
  input  logic [3:0]          t1_basis_i,
  input  logic [3:0]          t2_basis_i,
  input  logic [7:0]          t1_factor_i,
  input  logic [7:0]          t2_factor_i,
  output bitc_pkg::lane_req_t req_o
);
  import bitc_pkg::*;

  logic                 obj1_q, obj1_d, obj2_q, obj2_d, dir_q, dir_d;
  blind_phase_e         ph_q, ph_d;
  logic [TimerBits-1:0] tmr_q, tmr_d;
  logic [11:0]          prod1, prod2;
  logic [TimerBits-1:0] load1, load2;
  logic [1:0]           r1, r2;
  logic                 rising, falling, longshort, is_sw, is_bl;

  // small 4x8 products for the timer loads
  assign prod1 = t1_basis_i * t1_factor_i;
  assign prod2 = t2_basis_i * t2_factor_i;
  assign load1 = TimerBits'({{(TimerBits > 12 ? TimerBits-12 : 0){1'b0}}, prod1} - 1'b1);
  assign load2 = TimerBits'({{(TimerBits > 12 ? TimerBits-12 : 0){1'b0}}, prod2} - 1'b1);

  assign rising    = ctl_i.changed & ctl_i.level;
  assign falling   = ctl_i.changed & ~ctl_i.level;
  assign longshort = mode_i[3];
  assign is_sw     = (func_i == FnSwitch);
  assign is_bl     = (func_i == FnBlind);
  assign r1        = ctl_i.level ? mode_i[3:2] : mode_i[1:0];
  assign r2        = ctl_i.level ? mode_i[7:6] : mode_i[5:4];

  always_comb begin
    obj1_d = obj1_q;
    obj2_d = obj2_q;
    dir_d  = dir_q;
    ph_d   = ph_q;
    tmr_d  = tmr_q;
    req_o  = '0;
    if (ctl_i.pwr) begin
      // power-on telegrams
      if (is_sw) begin
        case (pwr_mode_i)
          RuleOn:  req_o = '{1'b1, 1'b1, 1'b1, 1'b1};
          RuleOff: req_o = '{1'b1, 1'b0, 1'b1, 1'b0};
          RuleToggle: req_o = '{1'b1, ctl_i.stored, 1'b1, ctl_i.stored};
          default: req_o = '0;
        endcase
      end else if (is_bl) begin
        case (pwr_mode_i)
          RuleOn:  req_o.two_vld = 1'b1;
          RuleOff: req_o.two_vld = 1'b1;
          default: req_o.two_vld = 1'b0;
        endcase
        req_o.two_val = (pwr_mode_i == RuleOn);
      end
    end else if (ctl_i.run && is_sw && ctl_i.changed) begin
      case (r1)
        RuleOn:     obj1_d = 1'b1;
        RuleOff:    obj1_d = 1'b0;
        RuleToggle: obj1_d = ~obj1_q;
        default:    obj1_d = obj1_q;
      endcase
      case (r2)
        RuleOn:     obj2_d = 1'b1;
        RuleOff:    obj2_d = 1'b0;
        RuleToggle: obj2_d = ~obj2_q;
        default:    obj2_d = obj2_q;
      endcase
      req_o = '{(r1 != RuleNone), obj1_d, (r2 != RuleNone), obj2_d};
    end else if (ctl_i.run && is_bl) begin
      // the move telegram value selection is repeated in the wait and first phases
      unique case (ph_q)
        PhWait: begin
          if (rising) begin
            if (!longshort) begin
              req_o.one_vld = 1'b1;
            end else if (mode_i[4]) begin
              dir_d = 1'b0; req_o.two_vld = 1'b1;
            end else if (mode_i[5]) begin
              dir_d = 1'b1; req_o.two_vld = 1'b1;
            end else if (mode_i[6]) begin
              dir_d = ~dir_q; req_o.two_vld = 1'b1;
            end
            req_o.two_val = dir_d;
            tmr_d = load1;
            ph_d  = PhFirst;
          end
        end
        PhFirst: begin
          if (tmr_q != '0) begin
            tmr_d = tmr_q - 1'b1;
            if (falling) begin
              req_o.one_vld = longshort;
              ph_d = PhWait;
            end
          end else if (!longshort) begin
            if (mode_i[4]) begin
              dir_d = 1'b0; req_o.two_vld = 1'b1;
            end else if (mode_i[5]) begin
              dir_d = 1'b1; req_o.two_vld = 1'b1;
            end else if (mode_i[6]) begin
              dir_d = ~dir_q; req_o.two_vld = 1'b1;
            end
            req_o.two_val = dir_d;
            tmr_d = load2;
            ph_d  = PhSecond;
          end else begin
            ph_d = PhWait;
          end
        end
        PhSecond: begin
          if (!longshort && tmr_q != '0) begin
            tmr_d = tmr_q - 1'b1;
            if (falling) begin
              req_o.one_vld = 1'b1;
              ph_d = PhWait;
            end
          end else begin
            ph_d = PhWait;
          end
        end
        default: ph_d = ph_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj1_q <= 1'b0;
      obj2_q <= 1'b0;
      dir_q  <= 1'b0;
      ph_q   <= PhWait;
      tmr_q  <= '0;
    end else begin
      obj1_q <= obj1_d;
      obj2_q <= obj2_d;
      dir_q  <= dir_d;
      ph_q   <= ph_d;
      tmr_q  <= tmr_d;
    end
  end

endmodule

FILE: sv/bitc_merge.sv
// Merging stage: queues lane telegrams and sends them in port order.
module bitc_merge #(
  parameter int unsigned NumPorts = bitc_pkg::NumPortsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  bitc_pkg::lane_req_t [NumPorts-1:0] req_i,
  output logic                               busy_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast
);
  import bitc_pkg::*;

  localparam int unsigned Slots = 2 * NumPorts;

  // slot 2p holds port p object one, slot 2p+1 its object two
  logic [Slots-1:0] pend_q, pend_d, val_q, val_d;
  logic [Slots-1:0] pick;
  logic [Slots-1:0] rest;
  logic [3:0]       num;
  logic             sel_val;
  logic             ov_q, ov_d;
  logic [3:0]       onum_q, onum_d;
  logic             oval_q, oval_d, olast_q, olast_d;
  logic             take;

  // lowest set bit, with object-one before object-two of the same port
  always_comb begin
    pick    = '0;
    num     = '0;
    sel_val = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick    = '0;
        pick[i] = 1'b1;
        sel_val = val_q[i];
        num     = (i % 2 == 0) ? 4'(i / 2) : 4'(i / 2 + 8);
      end
    end
  end

  assign rest = pend_q & ~pick;
  assign take = ~ov_q | m_axis_tready;

  always_comb begin
    pend_d  = pend_q;
    val_d   = val_q;
    ov_d    = ov_q & ~m_axis_tready;
    onum_d  = onum_q;
    oval_d  = oval_q;
    olast_d = olast_q;
    if (take && pend_q != '0) begin
      ov_d    = 1'b1;
      onum_d  = num;
      oval_d  = sel_val;
      olast_d = (rest == '0);
      pend_d  = rest;
    end
    if (load_i) begin
      for (int p = 0; p < NumPorts; p++) begin
        pend_d[2*p]   = req_i[p].one_vld;
        val_d[2*p]    = req_i[p].one_val;
        pend_d[2*p+1] = req_i[p].two_vld;
        val_d[2*p+1]  = req_i[p].two_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    onum_q  <= onum_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign busy_o        = (pend_q != '0);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, oval_q, onum_q};
  assign m_axis_tlast  = olast_q;

endmodule

FILE: sv/binary_input_telegram_controller.sv
// Top level: configuration, tick front end, port lanes and telegram merge.
// Each accepted tick beat is evaluated by all port lanes in the cycle it is
// accepted; the telegrams it causes (0 to 2*NUM_PORTS) then leave one per
// cycle while m_axis_tready is high, from the merge stage, object one before
// object two within a port, in port order. A new tick is taken once the merge
// queue is empty (its last telegram may still sit in the output register), so
// the tick rate is bounded by the single output port of the merge stage.
module binary_input_telegram_controller #(
  parameter int unsigned NUM_PORTS  = bitc_pkg::NumPortsDef,
  parameter int unsigned TIMER_BITS = bitc_pkg::TimerBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bitc_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [bitc_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // sample_first, sample_settled
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // object_number, object_value
  output logic                                m_axis_tlast   // last_of_tick
);
  import bitc_pkg::*;

  logic        app_q;
  logic [31:0] func_q;
  logic [63:0] modes_q, bases_q, t1f_q, t2f_q;
  logic [15:0] pwr_q;
  logic [7:0]  cnt_q, cnt_d, lvl_q, lvl_d;
  logic [7:0]  first, settled, chg, lvl;
  logic        acc, busy, run, pwr;
  lane_ctl_t [NUM_PORTS-1:0] ctl;
  lane_req_t [NUM_PORTS-1:0] req;

  assign first   = s_axis_tdata[7:0];
  assign settled = s_axis_tdata[15:8];
  assign s_axis_tready = ~busy;
  assign acc     = s_axis_tvalid & s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_q <= 1'b0; func_q <= '0; modes_q <= '0; pwr_q <= '0;
      bases_q <= '0; t1f_q <= '0; t2f_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAppRunning: app_q   <= cfg_data_i[0];
        RegPortFunc:   func_q  <= cfg_data_i[31:0];
        RegPortModes:  modes_q <= cfg_data_i;
        RegPwrModes:   pwr_q   <= cfg_data_i[15:0];
        RegTimerBases: bases_q <= cfg_data_i;
        RegT1Factors:  t1f_q   <= cfg_data_i;
        RegT2Factors:  t2f_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick front end: countdown, edges, level
  assign run = acc & app_q & (cnt_q == '0);
  assign pwr = acc & app_q & (cnt_q == 8'd1);
  assign chg = lvl_q ^ first;
  assign lvl = (chg != '0) ? settled : lvl_q;

  always_comb begin
    cnt_d = cnt_q;
    lvl_d = lvl_q;
    if (acc && app_q && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 8'd1) lvl_d = first;
    end else if (run) begin
      lvl_d = lvl;
    end
    if (cfg_we_i && cfg_idx_i == RegPwrDelay) cnt_d = cfg_data_i[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lvl_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      lvl_q <= lvl_d;
    end
  end

  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_lane
    assign ctl[p] = '{run, pwr, chg[p], lvl[p], first[p]};
    bitc_lane #(.TimerBits(TIMER_BITS)) u_lane (
      .clk_i, .rst_ni,
      .ctl_i      (ctl[p]),
      .func_i     (func_q[4*p +: 4]),
      .mode_i     (modes_q[8*p +: 8]),
      .pwr_mode_i (pwr_q[2*p +: 2]),
      .t1_basis_i (bases_q[4*p +: 4]),
      .t2_basis_i (bases_q[32+4*p +: 4]),
      .t1_factor_i(t1f_q[8*p +: 8]),
      .t2_factor_i(t2f_q[8*p +: 8]),
      .req_o      (req[p])
    );
  end

  bitc_merge #(.NumPorts(NUM_PORTS)) u_merge (
    .clk_i, .rst_ni,
    .load_i (acc),
    .req_i  (req),
    .busy_o (busy),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule
